// File: design/anm_pkg.sv
// Shared constants for the active node marker: field widths, register indexes and reset values.
package anm_pkg;

  localparam int GENE_W      = 7;
  localparam int CNT_OUT_W   = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int IN_CNT_W    = 6;
  localparam int NODE_CNT_W  = 7;
  localparam int OUT_CNT_W   = 5;
  localparam int GPN_W       = 3;
  localparam int ARITY_TBL_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GENES_PER_NODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ARITY_TABLE    = 3'd4;

  localparam logic [IN_CNT_W-1:0]    RST_INPUT_COUNT    = 6'd2;
  localparam logic [NODE_CNT_W-1:0]  RST_NODE_COUNT     = 7'd64;
  localparam logic [OUT_CNT_W-1:0]   RST_OUTPUT_COUNT   = 5'd1;
  localparam logic [GPN_W-1:0]       RST_GENES_PER_NODE = 3'd3;
  localparam logic [ARITY_TBL_W-1:0] RST_ARITY_TABLE    = 32'hAAAA_AAAA;

endpackage

// File: design/cgp_active_node_marker.sv
// Active node marker: stores a graph chromosome gene by gene and reports its active nodes.
//
// Usage: genes arrive on the input channel (in_valid_i / in_stall_o), one word per gene,
// the final gene flagged by last_gene_i. Genes are taken one per cycle while loading. After
// the final gene the block stalls its input while one sequencer and one gene store read
// port do the work: first it reads back each output gene to mark its target, then it scans
// from the highest node address down, passing over an unused node and, for a used one,
// reading its function gene, then one store word per followed connection. Results then
// leave on the output channel (out_valid_o / out_stall_i), one word per active node in
// ascending address order, each carrying the total count; the final word has last_result_o
// set. A chromosome with no active node gives a single word with none_active_o set.
// The emit pass walks one node address per cycle from the first node to the last active one.
// The output register decouples the receiver: a stalled result holds, the walk pauses, and
// the input is taken again as soon as the final result sits in the output register.
// Configuration (cfg_we_i, cfg_index_i, cfg_data_i) is to be written by the user only while
// idle; the block itself does not enforce this. Reset restores the register defaults and
// clears the used map and all control state; the gene store is not cleared and needs no pass.
module cgp_active_node_marker #(
  parameter int MAX_NODES          = 64,
  parameter int MAX_INPUTS         = 32,
  parameter int MAX_GENES_PER_NODE = 4,
  parameter int MAX_OUTPUTS        = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [anm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [anm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [anm_pkg::GENE_W-1:0]        gene_i,
  input  logic                              last_gene_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [anm_pkg::GENE_W-1:0]        node_address_o,
  output logic [anm_pkg::CNT_OUT_W-1:0]     active_count_o,
  output logic                              none_active_o,
  output logic                              last_result_o
);

  localparam int GeneW     = anm_pkg::GENE_W;
  localparam int StoreD    = MAX_NODES * MAX_GENES_PER_NODE + MAX_OUTPUTS;
  localparam int SAW       = $clog2(StoreD);
  localparam int PW        = $clog2(StoreD + 1);
  localparam int MapD      = MAX_INPUTS + MAX_NODES;
  localparam int MAW       = $clog2(MapD);
  localparam int AW        = $clog2(MapD + 1);
  localparam int CW        = (AW > GeneW) ? AW : GeneW;
  localparam int GW        = $clog2(MAX_GENES_PER_NODE + 1);
  localparam int OW        = $clog2(MAX_OUTPUTS + 1);
  localparam int CNW       = $clog2(MAX_NODES + 1);

  localparam logic [2:0] S_LOAD      = 3'd0;
  localparam logic [2:0] S_OUT       = 3'd1;
  localparam logic [2:0] S_SCAN_CHK  = 3'd2;
  localparam logic [2:0] S_SCAN_FN   = 3'd3;
  localparam logic [2:0] S_SCAN_CONN = 3'd4;
  localparam logic [2:0] S_EMIT      = 3'd5;

  // configuration
  logic [anm_pkg::IN_CNT_W-1:0]    input_count_q;
  logic [anm_pkg::NODE_CNT_W-1:0]  node_count_q;
  logic [anm_pkg::OUT_CNT_W-1:0]   output_count_q;
  logic [anm_pkg::GPN_W-1:0]       genes_per_node_q;
  logic [anm_pkg::ARITY_TBL_W-1:0] arity_table_q;

  // control
  logic [2:0]         state_q, state_d;
  logic [PW-1:0]      load_pos_q, load_pos_d;
  logic [PW-1:0]      len_q, len_d;
  logic [PW-1:0]      p_q, p_d;
  logic [AW-1:0]      a_q, a_d;
  logic [1:0]         j_q, j_d;
  logic [1:0]         arity_q, arity_d;
  logic [CNW-1:0]     cnt_q, cnt_d;
  logic [CNW-1:0]     k_q, k_d;
  logic [MapD-1:0]    map_q, map_d;
  logic               rd_mark_q, rd_mark_d;
  logic               out_vld_q, out_vld_d;

  // payload
  logic [GeneW-1:0]   rd_data_q;
  logic [GeneW-1:0]   out_addr_q, out_addr_d;
  logic [CNW-1:0]     out_cnt_q, out_cnt_d;
  logic               out_none_q, out_none_d;
  logic               out_last_q, out_last_d;

  logic [GeneW-1:0]   store_mem [StoreD];

  // derived config and datapath
  logic [AW-1:0]      ni, nn, limit, naddr, nidx;
  logic [OW-1:0]      no;
  logic [GW-1:0]      gpn, conns;
  logic [PW-1:0]      first;
  logic [SAW-1:0]     base, rd_addr;
  logic               rd_en, st_we, in_acc, out_free;
  logic               mark_set, mark_new, used;
  logic [MAW-1:0]     mark_idx;
  logic [1:0]         ar_raw, ar_sat;

  always_comb begin
    ni    = (input_count_q > MAX_INPUTS) ? AW'(MAX_INPUTS) : AW'(input_count_q);
    nn    = (node_count_q > MAX_NODES) ? AW'(MAX_NODES) : AW'(node_count_q);
    limit = ni + nn;
    no    = (output_count_q > MAX_OUTPUTS) ? OW'(MAX_OUTPUTS) : OW'(output_count_q);
    if (genes_per_node_q < 3'd2) begin
      gpn = GW'(2);
    end else if (genes_per_node_q > MAX_GENES_PER_NODE) begin
      gpn = GW'(MAX_GENES_PER_NODE);
    end else begin
      gpn = GW'(genes_per_node_q);
    end
    conns = gpn - 1'b1;
    naddr = a_q - 1'b1;
    nidx  = naddr - ni;
    base  = SAW'(SAW'(nidx) * SAW'(gpn));
    len_d = (load_pos_q < PW'(StoreD)) ? PW'(load_pos_q + 1'b1) : load_pos_q;
    first = (len_d > PW'(no)) ? PW'(len_d - PW'(no)) : '0;
  end

  // marking of a gene read back from the store
  always_comb begin
    mark_idx = rd_data_q[MAW-1:0];
    mark_set = rd_mark_q && (CW'(rd_data_q) < CW'(limit));
    mark_new = mark_set && !map_q[mark_idx] && (CW'(rd_data_q) >= CW'(ni));
    used     = map_q[naddr[MAW-1:0]] || (mark_set && (CW'(rd_data_q) == CW'(naddr)));
    ar_raw   = arity_table_q[{rd_data_q[3:0], 1'b0} +: 2];
    if (rd_data_q[GeneW-1:4] != '0) begin
      ar_sat = 2'd0;
    end else if (GW'(ar_raw) > conns) begin
      ar_sat = 2'(conns);
    end else begin
      ar_sat = ar_raw;
    end
  end

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign st_we      = in_acc && (load_pos_q < PW'(StoreD));
  assign out_free   = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    load_pos_d = load_pos_q;
    p_d        = p_q;
    a_d        = a_q;
    j_d        = j_q;
    arity_d    = arity_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    map_d      = map_q;
    rd_mark_d  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    out_vld_d  = out_vld_q && out_stall_i;
    out_addr_d = out_addr_q;
    out_cnt_d  = out_cnt_q;
    out_none_d = out_none_q;
    out_last_d = out_last_q;

    if (mark_set) begin
      map_d[mark_idx] = 1'b1;
    end
    if (mark_new) begin
      cnt_d = CNW'(cnt_q + 1'b1);
    end

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          load_pos_d = len_d;
          if (last_gene_i) begin
            load_pos_d = '0;
            map_d      = '0;
            cnt_d      = '0;
            p_d        = first;
            state_d    = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (p_q < len_q) begin
          rd_en     = 1'b1;
          rd_addr   = p_q[SAW-1:0];
          rd_mark_d = 1'b1;
          p_d       = PW'(p_q + 1'b1);
        end else begin
          a_d     = limit;
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (a_q > ni) begin
          if (used) begin
            rd_en   = 1'b1;
            rd_addr = SAW'(base + SAW'(conns));
            state_d = S_SCAN_FN;
          end else begin
            a_d = naddr;
          end
        end else begin
          a_d     = ni;
          k_d     = '0;
          state_d = S_EMIT;
        end
      end
      S_SCAN_FN: begin
        arity_d = ar_sat;
        j_d     = '0;
        state_d = S_SCAN_CONN;
      end
      S_SCAN_CONN: begin
        if (j_q < arity_q) begin
          rd_en     = 1'b1;
          rd_addr   = SAW'(base + SAW'(j_q));
          rd_mark_d = 1'b1;
          j_d       = j_q + 1'b1;
        end else begin
          a_d     = naddr;
          state_d = S_SCAN_CHK;
        end
      end
      S_EMIT: begin
        if (cnt_q == '0) begin
          if (out_free) begin
            out_vld_d  = 1'b1;
            out_addr_d = '0;
            out_cnt_d  = '0;
            out_none_d = 1'b1;
            out_last_d = 1'b1;
            state_d    = S_LOAD;
          end
        end else if (map_q[a_q[MAW-1:0]]) begin
          if (out_free) begin
            out_vld_d  = 1'b1;
            out_addr_d = GeneW'(a_q);
            out_cnt_d  = cnt_q;
            out_none_d = 1'b0;
            out_last_d = (CNW'(k_q + 1'b1) == cnt_q);
            k_d        = CNW'(k_q + 1'b1);
            a_d        = AW'(a_q + 1'b1);
            if (CNW'(k_q + 1'b1) == cnt_q) begin
              state_d = S_LOAD;
            end
          end
        end else begin
          a_d = AW'(a_q + 1'b1);
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_count_q    <= anm_pkg::RST_INPUT_COUNT;
      node_count_q     <= anm_pkg::RST_NODE_COUNT;
      output_count_q   <= anm_pkg::RST_OUTPUT_COUNT;
      genes_per_node_q <= anm_pkg::RST_GENES_PER_NODE;
      arity_table_q    <= anm_pkg::RST_ARITY_TABLE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        anm_pkg::REG_INPUT_COUNT:    input_count_q    <= cfg_data_i[anm_pkg::IN_CNT_W-1:0];
        anm_pkg::REG_NODE_COUNT:     node_count_q     <= cfg_data_i[anm_pkg::NODE_CNT_W-1:0];
        anm_pkg::REG_OUTPUT_COUNT:   output_count_q   <= cfg_data_i[anm_pkg::OUT_CNT_W-1:0];
        anm_pkg::REG_GENES_PER_NODE: genes_per_node_q <= cfg_data_i[anm_pkg::GPN_W-1:0];
        anm_pkg::REG_ARITY_TABLE:    arity_table_q    <= cfg_data_i[anm_pkg::ARITY_TBL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      load_pos_q <= '0;
      len_q      <= '0;
      p_q        <= '0;
      a_q        <= '0;
      j_q        <= '0;
      arity_q    <= '0;
      cnt_q      <= '0;
      k_q        <= '0;
      map_q      <= '0;
      rd_mark_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_pos_q <= load_pos_d;
      if (in_acc && last_gene_i) begin
        len_q <= len_d;
      end
      p_q        <= p_d;
      a_q        <= a_d;
      j_q        <= j_d;
      arity_q    <= arity_d;
      cnt_q      <= cnt_d;
      k_q        <= k_d;
      map_q      <= map_d;
      rd_mark_q  <= rd_mark_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_addr_q <= out_addr_d;
    out_cnt_q  <= out_cnt_d;
    out_none_q <= out_none_d;
    out_last_q <= out_last_d;
  end

  // gene store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[load_pos_q[SAW-1:0]] <= gene_i;
    end
    if (rd_en) begin
      rd_data_q <= store_mem[rd_addr];
    end
  end

  assign out_valid_o    = out_vld_q;
  assign node_address_o = out_addr_q;
  assign active_count_o = anm_pkg::CNT_OUT_W'(out_cnt_q);
  assign none_active_o  = out_none_q;
  assign last_result_o  = out_last_q;

  a_mark_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_mark_q |-> ($past(state_q) == S_OUT || $past(state_q) == S_SCAN_CONN))
    else $error("mark pending without a gene read");

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNW'(MAX_NODES))
    else $error("active count above node maximum");

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_none_q) |-> (out_last_q && out_cnt_q == '0))
    else $error("empty result not final or has count");

  a_emit_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && cnt_q != '0) |-> (k_q < cnt_q))
    else $error("emit index past active count");

  a_load_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD) |-> (load_pos_q == '0 && len_q <= PW'(StoreD)))
    else $error("load position not rewound after last gene");

endmodule
